// File: src/mot_pkg.sv
`timescale 1ns / 1ps
// Package for masked_otsu_threshold: shared widths and limits.
// No dependencies.
package mot_pkg;

  localparam int MAX_PIXELS_LOG2 = 22;
  localparam int NUM_BINS        = 256;
  localparam int W_BIN_ADDR      = 8;

  // count and bin width: both reach 2^MAX_PIXELS_LOG2
  localparam int W_CNT = MAX_PIXELS_LOG2 + 1;
  // sum of g*h[g] stays at most 255 * 2^MAX_PIXELS_LOG2
  localparam int W_S   = MAX_PIXELS_LOG2 + 8;
  localparam int W_A   = W_S + W_CNT;    // S*w0, M*s0 and their difference
  localparam int W_DEN = 2 * W_CNT;      // w0*(M-w0)
  localparam int W_SQ  = 2 * W_A;        // d^2
  localparam int W_BIG = W_SQ + W_DEN;   // d^2 * den

  localparam logic [W_CNT-1:0] PIX_LIMIT = W_CNT'(1) << MAX_PIXELS_LOG2;

endpackage

// File: src/masked_otsu_threshold.sv
`timescale 1ns / 1ps
// masked_otsu_threshold top level: histogram, frame scan and shared multiplier.
// Depends on mot_pkg and mot_ram.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, pixel,       | sink
//          | in_mask, last                    |
//  out     | out_valid, out_stall, threshold, | source
//          | empty_res, overflow              |
//
// After reset a clearing pass zeroes the histogram; in_stall is high.
// An unmasked pixel is taken in S_IDLE alone; a masked-in pixel below the count
// limit also passes S_ACC (bin read-modify-write via the histogram RAM port).
// On a last pixel the frame pass runs: S_SUM_A/S_SUM_B over all bins for the
// total sum, then per bin S_SCAN_A to S_SCAN_C and S_NEXT plus, for each valid
// split, six shift-add multiplies on the one shared multiplier.
// The scan zeroes each bin as it goes. A result waits in the output register
// while the next frame's pixels are taken; only the next frame end waits on it.

module masked_otsu_threshold
  import mot_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel,
  input  logic        in_mask,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  threshold,
  output logic        empty_res,
  output logic        overflow
);

  typedef enum logic [11:0] {
    S_INIT   = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_ACC    = 12'b0000_0000_0100,
    S_LAST   = 12'b0000_0000_1000,
    S_SUM_A  = 12'b0000_0001_0000,
    S_SUM_B  = 12'b0000_0010_0000,
    S_SCAN_A = 12'b0000_0100_0000,
    S_SCAN_B = 12'b0000_1000_0000,
    S_SCAN_C = 12'b0001_0000_0000,
    S_MUL    = 12'b0010_0000_0000,
    S_NEXT   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  // multiply sequence for one split
  typedef enum logic [2:0] {
    OP_A,     // S * w0
    OP_B,     // M * s0
    OP_DEN,   // w0 * (M - w0)
    OP_SQ,    // d * d
    OP_LHS,   // d^2 * best_den
    OP_RHS    // best_sq * den
  } op_t;

  state_t                  state;
  op_t                     op;
  logic [W_BIN_ADDR-1:0]   g;
  logic [W_BIN_ADDR-1:0]   pix_r;
  logic [W_CNT-1:0]        cnt;
  logic                    ovf;
  logic                    last_pend;

  logic [W_S-1:0]          s_tot;
  logic [W_S-1:0]          s0;
  logic [W_CNT-1:0]        w0;
  logic [W_A-1:0]          a_r;
  logic [W_A-1:0]          b_r;
  logic [W_DEN-1:0]        den_r;
  logic [W_SQ-1:0]         dsq_r;
  logic [W_BIG-1:0]        lhs_r;
  logic [W_SQ-1:0]         best_sq;
  logic [W_DEN-1:0]        best_den;
  logic [W_BIN_ADDR-1:0]   best_t;

  // shared shift-add multiplier
  logic [W_BIG-1:0]        mc;
  logic [W_A-1:0]          mp;
  logic [W_BIG-1:0]        prod;
  logic [W_BIG-1:0]        prod_next;

  logic [W_A-1:0]          d_abs;
  logic [W_S-1:0]          gh;

  // histogram RAM
  logic                    ram_we;
  logic [W_BIN_ADDR-1:0]   ram_waddr;
  logic [W_CNT-1:0]        ram_wdata;
  logic [W_BIN_ADDR-1:0]   ram_raddr;
  logic [W_CNT-1:0]        ram_rdata;

  logic                    in_acc;
  logic                    use_bin;

  mot_ram #(
    .WIDTH (W_CNT),
    .DEPTH (NUM_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign use_bin   = in_mask && (cnt != PIX_LIMIT);

  assign prod_next = mp[0] ? (prod + mc) : prod;
  assign d_abs     = (a_r >= b_r) ? (a_r - b_r) : (b_r - a_r);
  assign gh        = W_S'(g) * W_S'(ram_rdata);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = g;
    ram_wdata = '0;
    ram_raddr = g;
    unique case (state)
      S_INIT:   ram_we = 1'b1;
      S_IDLE:   ram_raddr = pixel;
      S_ACC: begin
        ram_we    = 1'b1;
        ram_waddr = pix_r;
        ram_wdata = ram_rdata + W_CNT'(1);
      end
      S_SCAN_B: ram_we = 1'b1;   // clear bin behind the scan
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      g         <= '0;
      cnt       <= '0;
      ovf       <= 1'b0;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
      op        <= OP_A;
    end else begin
      // in S_FIN the result load below decides out_valid
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          g <= g + 1'b1;
          if (g == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            pix_r     <= pixel;
            last_pend <= last;
            if (in_mask && !use_bin) begin
              ovf <= 1'b1;
            end
            if (use_bin) begin
              cnt   <= cnt + 1'b1;
              state <= S_ACC;
            end else if (last) begin
              state <= S_LAST;
            end
          end
        end
        S_ACC: begin
          state <= last_pend ? S_LAST : S_IDLE;
        end
        S_LAST: begin
          g        <= '0;
          s_tot    <= '0;
          s0       <= '0;
          w0       <= '0;
          best_sq  <= '0;
          best_den <= W_DEN'(1);
          best_t   <= '0;
          state    <= (cnt == '0) ? S_FIN : S_SUM_A;
        end
        S_SUM_A:  state <= S_SUM_B;
        S_SUM_B: begin
          s_tot <= s_tot + gh;
          g     <= g + 1'b1;
          state <= (g == '1) ? S_SCAN_A : S_SUM_A;
        end
        S_SCAN_A: state <= S_SCAN_B;
        S_SCAN_B: begin
          w0    <= w0 + ram_rdata;
          s0    <= s0 + gh;
          state <= S_SCAN_C;
        end
        S_SCAN_C: begin
          // both classes must be non-empty
          if (w0 == '0 || w0 >= cnt) begin
            state <= S_NEXT;
          end else begin
            op    <= OP_A;
            mc    <= W_BIG'(s_tot);
            mp    <= W_A'(w0);
            prod  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mp == '0) begin
            prod <= '0;
            unique case (op)
              OP_A: begin
                a_r <= prod[W_A-1:0];
                op  <= OP_B;
                mc  <= W_BIG'(s0);
                mp  <= W_A'(cnt);
              end
              OP_B: begin
                b_r <= prod[W_A-1:0];
                op  <= OP_DEN;
                mc  <= W_BIG'(w0);
                mp  <= W_A'(cnt - w0);
              end
              OP_DEN: begin
                den_r <= prod[W_DEN-1:0];
                op    <= OP_SQ;
                mc    <= W_BIG'(d_abs);
                mp    <= d_abs;
              end
              OP_SQ: begin
                dsq_r <= prod[W_SQ-1:0];
                op    <= OP_LHS;
                mc    <= prod;
                mp    <= W_A'(best_den);
              end
              OP_LHS: begin
                lhs_r <= prod;
                op    <= OP_RHS;
                mc    <= W_BIG'(best_sq);
                mp    <= W_A'(den_r);
              end
              OP_RHS: begin
                // strictly greater: first maximum is kept
                if (lhs_r > prod) begin
                  best_sq  <= dsq_r;
                  best_den <= den_r;
                  best_t   <= g;
                end
                state <= S_NEXT;
              end
              default: state <= S_NEXT;
            endcase
          end else begin
            prod <= prod_next;
            mc   <= mc << 1;
            mp   <= mp >> 1;
          end
        end
        S_NEXT: begin
          g     <= g + 1'b1;
          state <= (g == '1) ? S_FIN : S_SCAN_A;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            threshold <= best_t;
            empty_res <= (cnt == '0);
            overflow  <= ovf;
            cnt       <= '0;
            ovf       <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= PIX_LIMIT)
    else $error("pixel count beyond limit");

  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !(out_valid && out_stall)) |=> out_valid)
    else $error("frame end did not load result");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (best_den != '0))
    else $error("best denominator is zero");

  a_masked_rmw: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_mask && cnt != PIX_LIMIT) |=> (state == S_ACC))
    else $error("masked pixel skipped bin update");

endmodule

// File: src/mot_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
